// ===== rtl/lbc_pkg.sv =====
// Shared types and constants for the load averaged blink controller.
package lbc_pkg;

  localparam int MAX_CH      = 4;
  localparam int MAG_MAX     = 32768;
  localparam int TOTAL_W     = 18;
  localparam int COUNT_W     = 20;
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_STATUS = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] CFG_THR_LOW    = 2'd0;
  localparam logic [1:0] CFG_THR_MEDIUM = 2'd1;
  localparam logic [1:0] CFG_THR_HIGH   = 2'd2;

  localparam logic [15:0] THR_LOW_RESET    = 16'd9830;
  localparam logic [15:0] THR_MEDIUM_RESET = 16'd19661;
  localparam logic [15:0] THR_HIGH_RESET   = 16'd26214;

  localparam logic [1:0] RATE_SLOW      = 2'd0;
  localparam logic [1:0] RATE_MEDIUM    = 2'd1;
  localparam logic [1:0] RATE_FAST      = 2'd2;
  localparam logic [1:0] RATE_VERY_FAST = 2'd3;

  localparam logic [3:0][COUNT_W-1:0] INTERVALS = {
    20'd50000, 20'd100000, 20'd200000, 20'd500000
  };

  // exact divide by three for totals below 2^18
  localparam int         DIV3_SHIFT = 20;
  localparam logic [18:0] DIV3_RECIP = 19'd349526;

  typedef struct packed {
    logic               opcode;
    logic [3:0]         enable_mask;
    logic signed [15:0] duty_zero;
    logic signed [15:0] duty_one;
    logic signed [15:0] duty_two;
    logic signed [15:0] duty_three;
    logic [15:0]        elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic        lamp_on;
    logic [15:0] overall_load;
    logic [1:0]  rate_level;
    logic        toggled;
  } out_item_t;

  typedef struct packed {
    logic                     is_tick;
    logic [MAX_CH-1:0]        mask;
    logic [MAX_CH-1:0][15:0]  mag;
    logic [15:0]              elapsed;
  } cmd_t;

endpackage

// ===== rtl/lbc_front.sv =====
// Front end: accepts input items and turns them into queued commands.
module lbc_front #(
  parameter int CHANNEL_COUNT = 4
) (
  input  logic            item_valid,
  output logic            item_stall,
  input  lbc_pkg::in_item_t item,
  input  logic            q_full,
  output logic            q_push,
  output lbc_pkg::cmd_t   q_cmd
);
  import lbc_pkg::*;

  localparam logic [MAX_CH-1:0] CHAN_MASK = MAX_CH'((1 << CHANNEL_COUNT) - 1);

  function automatic logic [15:0] mag16(input logic signed [15:0] d);
    logic [15:0] neg;
    begin
      neg = 16'(-d);
      mag16 = d[15] ? neg : d;
    end
  endfunction

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  always_comb begin
    q_cmd.is_tick = (item.opcode == OP_TICK);
    q_cmd.mask    = item.enable_mask & CHAN_MASK;
    q_cmd.mag[0]  = mag16(item.duty_zero);
    q_cmd.mag[1]  = mag16(item.duty_one);
    q_cmd.mag[2]  = mag16(item.duty_two);
    q_cmd.mag[3]  = mag16(item.duty_three);
    q_cmd.elapsed = item.elapsed_us;
  end

endmodule

// ===== rtl/lbc_queue.sv =====
// Short command queue between the front end and the back end.
module lbc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lbc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output lbc_pkg::cmd_t pop_cmd,
  output logic          nonempty
);
  import lbc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_CNT);
  assign nonempty = (count != '0);
  assign pop_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lbc_back.sv =====
// Back end: history rings, load average, blink timing and result register.
module lbc_back #(
  parameter int CHANNEL_COUNT = 4,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  lbc_pkg::cmd_t      cmd_in,
  output logic               cmd_pop,
  input  logic               cfg_write_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               result_valid,
  input  logic               result_stall,
  output lbc_pkg::out_item_t result
);
  import lbc_pkg::*;

  localparam int CH_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int POS_W   = $clog2(HISTORY_DEPTH);
  localparam int SLOTS   = CHANNEL_COUNT * HISTORY_DEPTH;
  localparam int ADDR_W  = $clog2(SLOTS);
  localparam int SUM_W   = $clog2(HISTORY_DEPTH * MAG_MAX + 1);
  localparam int RSHIFT  = SUM_W + POS_W;
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << RSHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_VAL);
  localparam logic [CH_W-1:0]    LAST_CH  = CH_W'(CHANNEL_COUNT - 1);
  localparam logic [POS_W-1:0]   LAST_POS = POS_W'(HISTORY_DEPTH - 1);
  localparam logic [ADDR_W-1:0]  RING_LEN = ADDR_W'(HISTORY_DEPTH);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TICK   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_MULT   = 3'd4;
  localparam logic [2:0] ST_ACCUM  = 3'd5;
  localparam logic [2:0] ST_DIVIDE = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  logic [2:0]          state;
  cmd_t                cmd;
  logic [CH_W-1:0]     ch;
  logic [POS_W-1:0]    pos  [CHANNEL_COUNT];
  logic [SUM_W-1:0]    sums [CHANNEL_COUNT];
  logic [15:0]         mem  [SLOTS];
  logic [SLOTS-1:0]    filled;
  logic [15:0]         rd_data;
  logic                rd_filled;
  logic [PROD_W-1:0]   prod;
  logic [TOTAL_W-1:0]  total;
  logic [2:0]          active;
  logic [15:0]         load;
  logic                lamp;
  logic [COUNT_W-1:0]  count;
  logic                toggle_flag;
  logic [15:0]         thr_low;
  logic [15:0]         thr_medium;
  logic [15:0]         thr_high;

  logic [ADDR_W-1:0]           addr;
  logic [15:0]                 cur_mag;
  logic [15:0]                 old_mag;
  logic [SUM_W-1:0]            sum_next;
  logic [15:0]                 avg;
  logic [TOTAL_W+18:0]         div3_prod;
  logic [15:0]                 mean;
  logic [COUNT_W:0]            tick_sum;
  logic [COUNT_W-1:0]          count_next;
  logic [1:0]                  rate_now;
  logic                        out_free;

  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;
  assign out_free = !result_valid || !result_stall;
  assign addr     = ADDR_W'(ch) * RING_LEN + ADDR_W'(pos[ch]);
  assign cur_mag  = cmd.mag[ch];
  assign old_mag  = rd_filled ? rd_data : 16'd0;
  assign sum_next = sums[ch] - SUM_W'(old_mag) + SUM_W'(cur_mag);
  assign avg      = 16'(prod >> RSHIFT);
  assign div3_prod = total * DIV3_RECIP;
  assign tick_sum  = {1'b0, count} + (COUNT_W + 1)'(cmd.elapsed);
  assign count_next = tick_sum[COUNT_W] ? '1 : tick_sum[COUNT_W-1:0];

  always_comb begin
    priority if (load < thr_low) begin
      rate_now = RATE_SLOW;
    end else if (load < thr_medium) begin
      rate_now = RATE_MEDIUM;
    end else if (load < thr_high) begin
      rate_now = RATE_FAST;
    end else begin
      rate_now = RATE_VERY_FAST;
    end
  end

  always_comb begin
    unique case (active)
      3'd0:    mean = 16'd0;
      3'd1:    mean = 16'(total);
      3'd2:    mean = 16'(total >> 1);
      3'd3:    mean = 16'(div3_prod >> DIV3_SHIFT);
      3'd4:    mean = 16'(total >> 2);
      default: mean = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_data <= mem[addr];
    end
    if (state == ST_UPDATE) begin
      mem[addr] <= cur_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else begin
      if (state == ST_READ) begin
        rd_filled <= filled[addr];
      end
      if (state == ST_UPDATE) begin
        filled[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      load         <= 16'd0;
      lamp         <= 1'b0;
      count        <= '0;
      result_valid <= 1'b0;
      thr_low      <= THR_LOW_RESET;
      thr_medium   <= THR_MEDIUM_RESET;
      thr_high     <= THR_HIGH_RESET;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        pos[i]  <= '0;
        sums[i] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_THR_LOW:    thr_low    <= cfg_data;
          CFG_THR_MEDIUM: thr_medium <= cfg_data;
          CFG_THR_HIGH:   thr_high   <= cfg_data;
          default:        ;
        endcase
      end
      if (result_valid && !result_stall && state != ST_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd         <= cmd_in;
            ch          <= '0;
            total       <= '0;
            active      <= 3'd0;
            toggle_flag <= 1'b0;
            state       <= cmd_in.is_tick ? ST_TICK : ST_READ;
          end
        end
        ST_TICK: begin
          if (count_next >= INTERVALS[rate_now]) begin
            lamp        <= !lamp;
            count       <= '0;
            toggle_flag <= 1'b1;
          end else begin
            count <= count_next;
          end
          state <= ST_DONE;
        end
        ST_READ: begin
          if (cmd.mask[ch]) begin
            state <= ST_UPDATE;
          end else if (ch == LAST_CH) begin
            state <= ST_DIVIDE;
          end else begin
            ch <= ch + 1'b1;
          end
        end
        ST_UPDATE: begin
          sums[ch] <= sum_next;
          pos[ch]  <= (pos[ch] == LAST_POS) ? '0 : pos[ch] + 1'b1;
          state    <= ST_MULT;
        end
        ST_MULT: begin
          prod  <= PROD_W'(sums[ch]) * PROD_W'(RECIP);
          state <= ST_ACCUM;
        end
        ST_ACCUM: begin
          total  <= total + TOTAL_W'(avg);
          active <= active + 1'b1;
          if (ch == LAST_CH) begin
            state <= ST_DIVIDE;
          end else begin
            ch    <= ch + 1'b1;
            state <= ST_READ;
          end
        end
        ST_DIVIDE: begin
          load  <= mean;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            result_valid <= 1'b1;
            result       <= '{lamp_on: lamp, overall_load: load,
                              rate_level: rate_now, toggled: toggle_flag};
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/load_averaged_blink_controller_top.sv =====
// Top level of the load averaged blink controller.
// A status item takes a ring read, ring write and sum update, scaling
// multiply and accumulate per enabled channel and a ring read per disabled
// channel, then the divide; a tick item takes the blink counter update.
// The back end's channel sequencer works one item at a time; a two-entry
// command queue lets new items in while the back end is busy, and the
// result register lets it finish an item while the previous result still
// waits. History starts out as zero through per-entry valid bits, so no
// clearing pass follows reset.
module load_averaged_blink_controller_top #(
  parameter int CHANNEL_COUNT = 4,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  lbc_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output lbc_pkg::out_item_t result,
  input  logic               cfg_write_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import lbc_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_nonempty;
  cmd_t q_in_cmd;
  cmd_t q_out_cmd;

  lbc_front #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_in_cmd)
  );

  lbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_out_cmd),
    .nonempty (q_nonempty)
  );

  lbc_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_nonempty),
    .cmd_in       (q_out_cmd),
    .cmd_pop      (q_pop),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/lbc_checker.sv =====
// Port-level checker for the load averaged blink controller, with its bind.
module lbc_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_stall,
  input lbc_pkg::out_item_t result,
  input logic               cfg_write_en,
  input logic [1:0]         cfg_index,
  input logic [15:0]        cfg_data
);
  import lbc_pkg::*;

  logic [15:0] thr_low;
  logic [15:0] thr_medium;
  logic [15:0] thr_high;
  logic        last_lamp;
  logic [1:0]  exp_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_low    <= THR_LOW_RESET;
      thr_medium <= THR_MEDIUM_RESET;
      thr_high   <= THR_HIGH_RESET;
      last_lamp  <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_THR_LOW:    thr_low    <= cfg_data;
          CFG_THR_MEDIUM: thr_medium <= cfg_data;
          CFG_THR_HIGH:   thr_high   <= cfg_data;
          default:        ;
        endcase
      end
      if (result_valid && !result_stall) begin
        last_lamp <= result.lamp_on;
      end
    end
  end

  always_comb begin
    priority if (result.overall_load < thr_low) begin
      exp_rate = RATE_SLOW;
    end else if (result.overall_load < thr_medium) begin
      exp_rate = RATE_MEDIUM;
    end else if (result.overall_load < thr_high) begin
      exp_rate = RATE_FAST;
    end else begin
      exp_rate = RATE_VERY_FAST;
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_rate_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.rate_level == exp_rate)
    else $error("rate level disagrees with load and thresholds");

  a_load_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.overall_load <= 16'd32768)
    else $error("load above full scale");

  a_toggle_lamp: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.toggled == (result.lamp_on != last_lamp))
    else $error("toggle flag disagrees with lamp change");

endmodule

bind load_averaged_blink_controller_top lbc_checker u_lbc_checker (.*);
